// ===== rtl/rbp_pkg.sv =====
package rbp_pkg;

   localparam int HANDLE_W = 7;
   localparam int COUNT_W  = 16;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;

   localparam int NUM_HANDLES_DEFAULT = 64;
   localparam int ZERO_HANDLE         = 0;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_GET     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNTRACKED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [HANDLE_W-1:0] handle;
      logic [COUNT_W-1:0]  amount;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] result_handle;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  remaining;
   } rsp_type;

   // state updates decided for one request
   typedef struct packed {
      logic pop;
      logic create;
      logic push;
      logic trk_set;
      logic trk_clr;
      logic rc_we;
   } ctl_type;

endpackage

// ===== rtl/rbp_ram.sv =====
module rbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on an address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rbp_update.sv =====
module rbp_update (
   input  rbp_pkg::req_type              item,
   input  logic                          trk_hit,
   input  logic [rbp_pkg::COUNT_W-1:0]   rc_data,
   input  logic                          stk_nonempty,
   input  logic [rbp_pkg::HANDLE_W-1:0]  stk_data,
   input  logic                          can_create,
   input  logic [rbp_pkg::HANDLE_W-1:0]  fresh_handle,
   output rbp_pkg::ctl_type              ctl,
   output logic [rbp_pkg::HANDLE_W-1:0]  target_handle,
   output logic [rbp_pkg::COUNT_W-1:0]   rc_wdata,
   output rbp_pkg::rsp_type              rsp
);

   always_comb begin
      logic [rbp_pkg::COUNT_W:0]    sum;
      logic [rbp_pkg::HANDLE_W-1:0] grant;
      logic                         granted;

      sum     = {1'b0, rc_data} + {1'b0, item.amount};
      grant   = stk_data;
      granted = 1'b0;

      ctl                = '0;
      target_handle      = item.handle;
      rc_wdata           = '0;
      rsp.result_handle  = item.handle;
      rsp.status         = rbp_pkg::ST_UNTRACKED;
      rsp.remaining      = '0;

      case (item.mode)
         rbp_pkg::MODE_GET: begin
            if (stk_nonempty) begin
               ctl.pop = 1'b1;
               grant   = stk_data;
               granted = 1'b1;
            end else if (can_create) begin
               ctl.create = 1'b1;
               grant      = fresh_handle;
               granted    = 1'b1;
            end
            if (granted) begin
               ctl.trk_set       = 1'b1;
               ctl.rc_we         = 1'b1;
               target_handle     = grant;
               rc_wdata          = item.amount;
               rsp.result_handle = grant;
               rsp.status        = rbp_pkg::ST_OK;
               rsp.remaining     = item.amount;
            end else begin
               rsp.result_handle = '0;
               rsp.status        = rbp_pkg::ST_EXHAUSTED;
            end
         end
         rbp_pkg::MODE_RELEASE, rbp_pkg::MODE_RESERVE: begin
            if (item.handle == rbp_pkg::HANDLE_W'(rbp_pkg::ZERO_HANDLE)) begin
               rsp.status = rbp_pkg::ST_ZERO;
            end else if (trk_hit) begin
               if (item.mode == rbp_pkg::MODE_RELEASE) begin
                  // a count of zero or one frees the handle, no wrap
                  if (rc_data <= rbp_pkg::COUNT_W'(1)) begin
                     ctl.trk_clr = 1'b1;
                     ctl.push    = 1'b1;
                     rsp.status  = rbp_pkg::ST_FREED;
                  end else begin
                     ctl.rc_we     = 1'b1;
                     rc_wdata      = rc_data - rbp_pkg::COUNT_W'(1);
                     rsp.status    = rbp_pkg::ST_OK;
                     rsp.remaining = rc_data - rbp_pkg::COUNT_W'(1);
                  end
               end else begin
                  ctl.rc_we     = 1'b1;
                  rc_wdata      = sum[rbp_pkg::COUNT_W] ? rbp_pkg::COUNT_MAX
                                                        : sum[rbp_pkg::COUNT_W-1:0];
                  rsp.status    = rbp_pkg::ST_OK;
                  rsp.remaining = sum[rbp_pkg::COUNT_W] ? rbp_pkg::COUNT_MAX
                                                        : sum[rbp_pkg::COUNT_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/refcounted_buffer_pool.sv =====
// channel   dir  payload           transfer when
// req_*     in   rbp_pkg::req_type req_valid & req_ready
// rsp_*     out  rbp_pkg::rsp_type rsp_valid & rsp_ready
//
// One request per cycle while the response register can drain. A request is latched
// with its count table and free stack reads issued at the same edge; the request stage
// then decides, writes back and loads the response register, which raises rsp_valid.
// Synchronous reset clears the stack pointer, the created count and the tracked
// bits; no clearing pass. A stalled response holds the request stage; the request
// side keeps taking items while the response register can drain.
module refcounted_buffer_pool #(
   parameter int NUM_HANDLES = rbp_pkg::NUM_HANDLES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbp_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(NUM_HANDLES);
   localparam int CNT_W = $clog2(NUM_HANDLES + 1);

   logic                         s0_valid_ff;
   rbp_pkg::req_type             s0_item_ff;
   logic                         rsp_valid_ff;
   rbp_pkg::rsp_type             rsp_data_ff;
   logic [CNT_W-1:0]             free_top_ff, free_top_in;
   logic [CNT_W-1:0]             created_ff, created_in;
   logic [NUM_HANDLES-1:0]       tracked_ff;

   logic                         rc_fwd_valid_ff;
   logic [IDX_W-1:0]             rc_fwd_addr_ff;
   logic [rbp_pkg::COUNT_W-1:0]  rc_fwd_data_ff;
   logic                         stk_fwd_valid_ff;
   logic [IDX_W-1:0]             stk_fwd_addr_ff;
   logic [rbp_pkg::HANDLE_W-1:0] stk_fwd_data_ff;

   logic                         fire, accept;
   logic [IDX_W-1:0]             s0_idx, pop_idx, tgt_idx, push_idx;
   logic                         in_range, trk_hit, push_ok;
   logic [rbp_pkg::COUNT_W-1:0]  rc_rdata, rc_data;
   logic [rbp_pkg::HANDLE_W-1:0] stk_rdata, stk_data, fresh_handle;
   rbp_pkg::ctl_type             ctl;
   logic [rbp_pkg::HANDLE_W-1:0] target_handle;
   logic [rbp_pkg::COUNT_W-1:0]  rc_wdata;
   rbp_pkg::rsp_type             rsp_next;

   assign fire      = s0_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s0_valid_ff || fire;
   assign accept    = req_valid && req_ready;

   assign s0_idx   = IDX_W'(s0_item_ff.handle - rbp_pkg::HANDLE_W'(1));
   assign pop_idx  = IDX_W'(free_top_ff - CNT_W'(1));
   assign push_idx = IDX_W'(free_top_ff);
   assign tgt_idx  = IDX_W'(target_handle - rbp_pkg::HANDLE_W'(1));

   assign in_range = (s0_item_ff.handle != rbp_pkg::HANDLE_W'(rbp_pkg::ZERO_HANDLE)) &&
                     (int'(s0_item_ff.handle) <= NUM_HANDLES);
   assign trk_hit  = in_range && tracked_ff[s0_idx];

   // last write to each memory, to cover a read issued at the same edge
   assign rc_data  = (rc_fwd_valid_ff && rc_fwd_addr_ff == s0_idx) ? rc_fwd_data_ff
                                                                   : rc_rdata;
   assign stk_data = (stk_fwd_valid_ff && stk_fwd_addr_ff == pop_idx) ? stk_fwd_data_ff
                                                                      : stk_rdata;

   assign fresh_handle = rbp_pkg::HANDLE_W'(created_ff + CNT_W'(1));
   assign push_ok      = ctl.push && (int'(free_top_ff) < NUM_HANDLES);

   rbp_update u_update (
      .item          (s0_item_ff),
      .trk_hit       (trk_hit),
      .rc_data       (rc_data),
      .stk_nonempty  (free_top_ff != '0),
      .stk_data      (stk_data),
      .can_create    (int'(created_ff) < NUM_HANDLES),
      .fresh_handle  (fresh_handle),
      .ctl           (ctl),
      .target_handle (target_handle),
      .rc_wdata      (rc_wdata),
      .rsp           (rsp_next)
   );

   always_comb begin
      free_top_in = free_top_ff;
      created_in  = created_ff;
      if (fire) begin
         if (ctl.pop) begin
            free_top_in = free_top_ff - CNT_W'(1);
         end else if (push_ok) begin
            free_top_in = free_top_ff + CNT_W'(1);
         end
         if (ctl.create) begin
            created_in = created_ff + CNT_W'(1);
         end
      end
   end

   rbp_ram #(
      .WIDTH (rbp_pkg::COUNT_W),
      .DEPTH (NUM_HANDLES)
   ) u_ref_count (
      .clock   (clock),
      .wr_en   (fire && ctl.rc_we),
      .wr_addr (tgt_idx),
      .wr_data (rc_wdata),
      .rd_en   (accept),
      .rd_addr (IDX_W'(req_data.handle - rbp_pkg::HANDLE_W'(1))),
      .rd_data (rc_rdata)
   );

   rbp_ram #(
      .WIDTH (rbp_pkg::HANDLE_W),
      .DEPTH (NUM_HANDLES)
   ) u_free_stack (
      .clock   (clock),
      .wr_en   (fire && push_ok),
      .wr_addr (push_idx),
      .wr_data (s0_item_ff.handle),
      .rd_en   (accept),
      .rd_addr (IDX_W'(free_top_in - CNT_W'(1))),
      .rd_data (stk_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         free_top_ff      <= '0;
         created_ff       <= '0;
         tracked_ff       <= '0;
         rc_fwd_valid_ff  <= 1'b0;
         stk_fwd_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s0_valid_ff <= 1'b1;
         end else if (fire) begin
            s0_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         free_top_ff <= free_top_in;
         created_ff  <= created_in;
         if (fire && ctl.trk_set) begin
            tracked_ff[tgt_idx] <= 1'b1;
         end
         if (fire && ctl.trk_clr) begin
            tracked_ff[tgt_idx] <= 1'b0;
         end
         if (fire && ctl.rc_we) begin
            rc_fwd_valid_ff <= 1'b1;
         end
         if (fire && push_ok) begin
            stk_fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_item_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_next;
      end
      if (fire && ctl.rc_we) begin
         rc_fwd_addr_ff <= tgt_idx;
         rc_fwd_data_ff <= rc_wdata;
      end
      if (fire && push_ok) begin
         stk_fwd_addr_ff <= push_idx;
         stk_fwd_data_ff <= s0_item_ff.handle;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stack_within_created: assert property (@(posedge clock) disable iff (reset)
      free_top_ff <= created_ff)
      else $error("free stack deeper than created handles");

   a_created_bound: assert property (@(posedge clock) disable iff (reset)
      int'(created_ff) <= NUM_HANDLES)
      else $error("created count beyond pool size");

   a_handle_conservation: assert property (@(posedge clock) disable iff (reset)
      $countones(tracked_ff) + int'(free_top_ff) == int'(created_ff))
      else $error("tracked plus free handles differ from created count");

   a_exhausted_zero: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_next.status == rbp_pkg::ST_EXHAUSTED) |=>
         (rsp_data.result_handle == '0 && rsp_data.remaining == '0))
      else $error("exhausted response carries a handle or count");

endmodule

// ===== tb/refcounted_buffer_pool_tb.sv =====
module refcounted_buffer_pool_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rbp_pkg::*;

   localparam int NUM_H = NUM_HANDLES_DEFAULT;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   refcounted_buffer_pool #(.NUM_HANDLES(NUM_H)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pool shadow state
   logic [HANDLE_W-1:0] free_list [NUM_H];
   int                  free_depth;
   int                  created;
   logic [COUNT_W-1:0]  ref_cnt [NUM_H];
   bit                  live [NUM_H];

   rsp_type     expected_rsp_q [$];
   dir_row_type directed_q [$];
   int          mismatches;
   int          requests_sent;
   int          results_seen;
   int          n_grant, n_freed, n_untracked, n_zero, n_exhausted, n_saturated;
   bit          sender_burst;
   bit          hold_req;

   function automatic rsp_type pool_predict(req_type r);
      rsp_type             o;
      logic [HANDLE_W-1:0] g;
      int unsigned         sum;
      int                  s;
      o.result_handle = r.handle;
      o.status = ST_UNTRACKED;
      o.remaining = '0;
      if (r.mode == MODE_GET) begin
         g = HANDLE_W'(ZERO_HANDLE);
         if (free_depth > 0) begin
            free_depth--;
            g = free_list[free_depth];
         end else if (created < NUM_H) begin
            created++;
            g = HANDLE_W'(created);
         end
         if (g != ZERO_HANDLE) begin
            live[g-1] = 1'b1;
            ref_cnt[g-1] = r.amount;
            o.result_handle = g;
            o.status = ST_OK;
            o.remaining = r.amount;
            n_grant++;
         end else begin
            o.result_handle = HANDLE_W'(ZERO_HANDLE);
            o.status = ST_EXHAUSTED;
            n_exhausted++;
         end
      end else if (r.mode == MODE_RELEASE || r.mode == MODE_RESERVE) begin
         s = int'(r.handle) - 1;
         if (r.handle == ZERO_HANDLE) begin
            o.status = ST_ZERO;
            n_zero++;
         end else if (r.handle > NUM_H || !live[s]) begin
            n_untracked++;
         end else if (r.mode == MODE_RELEASE) begin
            if (ref_cnt[s] <= 1) begin
               // count-zero entries are freed too, no wrap
               live[s] = 1'b0;
               ref_cnt[s] = '0;
               if (free_depth < NUM_H) begin
                  free_list[free_depth] = r.handle;
                  free_depth++;
               end
               o.status = ST_FREED;
               n_freed++;
            end else begin
               ref_cnt[s] = ref_cnt[s] - COUNT_W'(1);
               o.status = ST_OK;
               o.remaining = ref_cnt[s];
            end
         end else begin
            sum = ref_cnt[s] + r.amount;
            if (sum > COUNT_MAX) begin
               sum = 32'(COUNT_MAX);
               n_saturated++;
            end
            ref_cnt[s] = sum[COUNT_W-1:0];
            o.status = ST_OK;
            o.remaining = ref_cnt[s];
         end
      end else begin
         n_untracked++;
      end
      return o;
   endfunction

   function automatic req_type pick_request(int wg, int wr, int ws);
      req_type r;
      int      roll;
      int      pool [$];
      roll = $urandom_range(0, wg + wr + ws + 1);
      if (roll < wg)
         r.mode = MODE_GET;
      else if (roll < wg + wr)
         r.mode = MODE_RELEASE;
      else if (roll < wg + wr + ws)
         r.mode = MODE_RESERVE;
      else
         r.mode = MODE_UNUSED;
      for (int i = 0; i < NUM_H; i++)
         if (live[i])
            pool.insert(pool.size(), i + 1);
      if (pool.size() > 0 && $urandom_range(0, 9) < 7)
         r.handle = HANDLE_W'(pool[$urandom_range(0, pool.size() - 1)]);
      else if ($urandom_range(0, 3) == 0)
         r.handle = HANDLE_W'($urandom_range(0, 127));
      else
         r.handle = HANDLE_W'($urandom_range(0, NUM_H));
      roll = $urandom_range(0, 19);
      if (roll < ((r.mode == MODE_GET) ? 17 : 12))
         r.amount = COUNT_W'($urandom_range(0, 3));
      else if (roll < 18)
         r.amount = COUNT_W'($urandom);
      else
         r.amount = COUNT_W'($urandom_range(16'hFFF0, 16'hFFFF));
      return r;
   endfunction

   function automatic void add_row(logic [MODE_W-1:0] m, logic [HANDLE_W-1:0] h,
                                   logic [COUNT_W-1:0] a, int typed,
                                   logic [HANDLE_W-1:0] rh = '0,
                                   logic [STATUS_W-1:0] st = ST_OK,
                                   logic [COUNT_W-1:0] rem = '0);
      dir_row_type row;
      row.req.mode = m;
      row.req.handle = h;
      row.req.amount = a;
      row.typed = (typed != 0);
      row.want.result_handle = rh;
      row.want.status = st;
      row.want.remaining = rem;
      directed_q.insert(directed_q.size(), row);
   endfunction

   task automatic send(req_type r, bit typed, rsp_type want);
      int      gap;
      rsp_type got;
      gap = sender_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      got = pool_predict(r);
      expected_rsp_q.insert(expected_rsp_q.size(), typed ? want : got);
      requests_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(int n, int wg, int wr, int ws);
      for (int i = 0; i < n; i++)
         send(pick_request(wg, wr, ws), 1'b0, '0);
   endtask

   task automatic check_response(rsp_type act);
      rsp_type want;
      results_seen++;
      if (expected_rsp_q.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result handle=%0d status=%0d remaining=%0d",
                     $realtime, act.result_handle, act.status, act.remaining);
      end else begin
         want = expected_rsp_q.pop_front();
         if (act.result_handle !== want.result_handle || act.status !== want.status ||
             act.remaining !== want.remaining) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result %0d mismatch: exp h=%0d st=%0d rem=%0d, got h=%0d st=%0d rem=%0d",
                        $realtime, results_seen, want.result_handle, want.status,
                        want.remaining, act.result_handle, act.status, act.remaining);
         end
      end
   endtask

   // result side: random stalls, bursts, and one long hold-off on request
   initial begin : receiver
      int gap;
      bit rcv_burst;
      rcv_burst = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if ($urandom_range(0, 63) == 0)
               rcv_burst = !rcv_burst;
            gap = rcv_burst ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_response(rsp_data);
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle = 0;
         else
            idle++;
      end
      $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      free_depth = 0;
      created = 0;
      for (int i = 0; i < NUM_H; i++) begin
         live[i] = 1'b0;
         ref_cnt[i] = '0;
         free_list[i] = '0;
      end
      mismatches = 0;
      requests_sent = 0;
      results_seen = 0;
      n_grant = 0; n_freed = 0; n_untracked = 0;
      n_zero = 0; n_exhausted = 0; n_saturated = 0;
      sender_burst = 1'b0;
      hold_req = 1'b0;

      // zero buffer, untracked, out of range, unused mode
      add_row(MODE_RELEASE, 7'd0, 16'd0, 1, 7'd0, ST_ZERO, 16'd0);
      add_row(MODE_RESERVE, 7'd0, 16'hFFFF, 1, 7'd0, ST_ZERO, 16'd0);
      add_row(MODE_RELEASE, 7'd5, 16'd1, 1, 7'd5, ST_UNTRACKED, 16'd0);
      add_row(MODE_RESERVE, 7'd127, 16'hFFFF, 1, 7'd127, ST_UNTRACKED, 16'd0);
      add_row(MODE_UNUSED, 7'd0, 16'h1234, 1, 7'd0, ST_UNTRACKED, 16'd0);
      add_row(MODE_UNUSED, 7'd64, 16'hFFFF, 1, 7'd64, ST_UNTRACKED, 16'd0);
      // count-zero get, then release frees without wrapping
      add_row(MODE_GET, 7'd0, 16'd0, 1, 7'd1, ST_OK, 16'd0);
      add_row(MODE_RELEASE, 7'd1, 16'd0, 1, 7'd1, ST_FREED, 16'd0);
      add_row(MODE_RELEASE, 7'd1, 16'd0, 1, 7'd1, ST_UNTRACKED, 16'd0);
      // reuse from free list, saturating reserve
      add_row(MODE_GET, 7'd99, 16'hFFFF, 1, 7'd1, ST_OK, 16'hFFFF);
      add_row(MODE_RESERVE, 7'd1, 16'hFFFF, 1, 7'd1, ST_OK, 16'hFFFF);
      add_row(MODE_RELEASE, 7'd1, 16'd0, 1, 7'd1, ST_OK, 16'hFFFE);
      add_row(MODE_GET, 7'd0, 16'd1, 1, 7'd2, ST_OK, 16'd1);
      add_row(MODE_GET, 7'd0, 16'd2, 1, 7'd3, ST_OK, 16'd2);
      add_row(MODE_RELEASE, 7'd2, 16'd0, 1, 7'd2, ST_FREED, 16'd0);
      add_row(MODE_RELEASE, 7'd3, 16'd0, 1, 7'd3, ST_OK, 16'd1);
      add_row(MODE_RELEASE, 7'd3, 16'd0, 1, 7'd3, ST_FREED, 16'd0);
      // LIFO: last freed comes back first
      add_row(MODE_GET, 7'd0, 16'd5, 1, 7'd3, ST_OK, 16'd5);
      add_row(MODE_GET, 7'd0, 16'd7, 1, 7'd2, ST_OK, 16'd7);
      add_row(MODE_GET, 7'd0, 16'h8000, 1, 7'd4, ST_OK, 16'h8000);
      add_row(MODE_RESERVE, 7'd4, 16'h7FFF, 1, 7'd4, ST_OK, 16'hFFFF);
      add_row(MODE_RESERVE, 7'd2, 16'd3, 0);
      add_row(MODE_RELEASE, 7'd65, 16'd0, 1, 7'd65, ST_UNTRACKED, 16'd0);
      add_row(MODE_RELEASE, 7'd4, 16'd0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[i])
         send(directed_q[i].req, directed_q[i].typed, directed_q[i].want);
      drain();

      run_phase(300, 40, 40, 18);
      drain();

      // stall the result side and keep offering back to back
      hold_req = 1'b1;
      sender_burst = 1'b1;
      run_phase(60, 45, 35, 18);
      sender_burst = 1'b0;
      run_phase(140, 45, 35, 18);
      drain();

      run_phase(300, 75, 15, 8);     // runs the pool dry
      drain();
      run_phase(300, 10, 75, 13);
      drain();
      sender_burst = 1'b1;
      run_phase(250, 30, 30, 38);
      sender_burst = 1'b0;
      drain();
      run_phase(250, 40, 40, 18);
      drain();
      run_phase(200, 70, 20, 8);
      drain();

      repeat (10) @(posedge clock);
      $display("Ran %0d requests: %0d grants, %0d frees, %0d exhausted, %0d untracked,",
               requests_sent, n_grant, n_freed, n_exhausted, n_untracked);
      $display("%0d zero-buffer hits, %0d saturated reserves, %0d mismatches",
               n_zero, n_saturated, mismatches);
      if (mismatches == 0 && expected_rsp_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
